@@ hw/rtl/bsm_pkg.sv @@
`default_nettype none

package bsm_pkg;

    typedef logic [7:0] data_t;

    typedef enum logic [7:0] {
        OP_PUSH = 8'd0,
        OP_ADD  = 8'd1,
        OP_SUB  = 8'd2,
        OP_DIV  = 8'd3,
        OP_MUL  = 8'd4,
        OP_POP  = 8'd5,
        OP_DONE = 8'd6
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DONE      = 3'd1,
        ST_DIVZERO   = 3'd2,
        ST_UNKNOWN   = 3'd3,
        ST_UNDERFLOW = 3'd4,
        ST_OVERFLOW  = 3'd5
    } status_t;

    localparam int DEPTH_W = 9;

endpackage

`default_nettype wire

@@ hw/rtl/bsm_cmd_if.sv @@
`default_nettype none

interface bsm_cmd_if;
    logic            valid;
    logic            ready;
    bsm_pkg::data_t  cmd;
    bsm_pkg::data_t  immediate;

    modport source (output valid, output cmd, output immediate, input ready);
    modport sink   (input valid, input cmd, input immediate, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bsm_rsp_if.sv @@
`default_nettype none

interface bsm_rsp_if;
    logic                           valid;
    logic                           ready;
    bsm_pkg::status_t               status;
    bsm_pkg::data_t                 result_value;
    logic [bsm_pkg::DEPTH_W-1:0]    stack_depth;

    modport source (output valid, output status, output result_value, output stack_depth,
                    input ready);
    modport sink   (input valid, input status, input result_value, input stack_depth,
                    output ready);
endinterface

`default_nettype wire

@@ hw/rtl/byte_stack_machine.sv @@
// Push, done, unknown opcode and stack-bound errors answer from idle, a zero divisor
// after two reads; pop reads once, arithmetic twice, divide then runs 8 divider steps.
// Throughput: one word at a time; the next word is taken once the response is out,
// the limit being the one-read-per-cycle stack memory and the bit-serial divider.
// Reset (rst_n, asynchronous, active low) empties the stack, clears the result and
// the halt flag; stack memory contents stay unknown and are never read before written.
`default_nettype none

module byte_stack_machine #(
    parameter int STACK_DEPTH = 256
) (
    input  wire        clk,
    input  wire        rst_n,
    bsm_cmd_if.sink    instr,
    bsm_rsp_if.source  resp
);
    import bsm_pkg::*;

    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int EXT_W  = (SP_W > DEPTH_W) ? SP_W : DEPTH_W;
    localparam logic [SP_W-1:0] SP_ONE  = SP_W'(1);
    localparam logic [SP_W-1:0] SP_TWO  = SP_W'(2);
    localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ_A = 4'b0010,
        S_READ_B = 4'b0100,
        S_DIVIDE = 4'b1000
    } state_t;

    // Stack storage: one write port, one registered read port.
    data_t stack_mem [STACK_DEPTH];

    state_t            state_reg, state_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    data_t             result_reg, result_next;
    logic              halted_reg, halted_next;
    logic              rsp_valid_reg, rsp_valid_next;
    status_t           status_reg, status_next;
    opcode_t           op_reg, op_next;
    data_t             left_reg, left_next;
    data_t             right_reg, right_next;
    data_t             quo_reg, quo_next;
    data_t             rem_reg, rem_next;
    logic [2:0]        cnt_reg, cnt_next;
    data_t             rd_data_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    data_t             mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic              accept;
    logic              finish;
    status_t           finish_status;
    logic [SP_W-1:0]   sp_eff;
    data_t             result_eff;
    logic [15:0]       product;
    logic [9:0]        trial;
    logic              fits;
    data_t             alu_out;
    logic [EXT_W-1:0]  sp_ext;

    // Take a new word only when idle and the response slot is free or freeing.
    assign instr.ready = (state_reg == S_IDLE) && (!rsp_valid_reg || resp.ready);
    assign accept      = instr.valid && instr.ready;

    // A halted machine restarts with an empty stack and a cleared result.
    assign sp_eff     = halted_reg ? '0 : sp_reg;
    assign result_eff = halted_reg ? '0 : result_reg;

    assign product = 16'(left_reg) * 16'(rd_data_reg);
    // One restoring divide step: shift in the next dividend bit, try the divisor.
    assign trial   = {1'b0, rem_reg, quo_reg[7]} - {2'b00, right_reg};
    assign fits    = !trial[9];

    always_comb
    begin
        unique case (op_reg)
            OP_ADD:  alu_out = left_reg + rd_data_reg;
            OP_SUB:  alu_out = left_reg - rd_data_reg;
            default: alu_out = product[7:0];
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        result_next    = result_reg;
        halted_next    = halted_reg;
        rsp_valid_next = rsp_valid_reg && !resp.ready;
        status_next    = status_reg;
        op_next        = op_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        finish         = 1'b0;
        finish_status  = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    halted_next = 1'b0;
                    sp_next     = sp_eff;
                    result_next = result_eff;
                    op_next     = opcode_t'(instr.cmd);
                    unique case (instr.cmd)
                        OP_PUSH:
                        begin
                            finish = 1'b1;
                            if (sp_eff >= SP_FULL)
                            begin
                                finish_status = ST_OVERFLOW;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = sp_eff[ADDR_W-1:0];
                                mem_wdata = instr.immediate;
                                sp_next   = sp_eff + SP_ONE;
                            end
                        end
                        OP_ADD, OP_SUB, OP_DIV, OP_MUL:
                        begin
                            if (sp_eff < SP_TWO)
                            begin
                                finish        = 1'b1;
                                finish_status = ST_UNDERFLOW;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = ADDR_W'(sp_eff - SP_ONE);
                                state_next = S_READ_A;
                            end
                        end
                        OP_POP:
                        begin
                            if (sp_eff == '0)
                            begin
                                finish        = 1'b1;
                                finish_status = ST_UNDERFLOW;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = ADDR_W'(sp_eff - SP_ONE);
                                state_next = S_READ_A;
                            end
                        end
                        OP_DONE:
                        begin
                            finish        = 1'b1;
                            finish_status = ST_DONE;
                        end
                        default:
                        begin
                            finish        = 1'b1;
                            finish_status = ST_UNKNOWN;
                        end
                    endcase
                end
            end
            S_READ_A:
            begin
                // Top of stack is on the read port now.
                if (op_reg == OP_POP)
                begin
                    result_next = rd_data_reg;
                    sp_next     = sp_reg - SP_ONE;
                    finish      = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    left_next  = rd_data_reg;
                    mem_re     = 1'b1;
                    mem_raddr  = ADDR_W'(sp_reg - SP_TWO);
                    state_next = S_READ_B;
                end
            end
            S_READ_B:
            begin
                // Second entry (right operand) is on the read port now.
                if (op_reg == OP_DIV)
                begin
                    if (rd_data_reg == '0)
                    begin
                        finish        = 1'b1;
                        finish_status = ST_DIVZERO;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        right_next = rd_data_reg;
                        quo_next   = left_reg;
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = S_DIVIDE;
                    end
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = ADDR_W'(sp_reg - SP_TWO);
                    mem_wdata  = alu_out;
                    sp_next    = sp_reg - SP_ONE;
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIVIDE:
            begin
                rem_next = fits ? trial[7:0] : {rem_reg[6:0], quo_reg[7]};
                quo_next = {quo_reg[6:0], fits};
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = ADDR_W'(sp_reg - SP_TWO);
                    mem_wdata  = {quo_reg[6:0], fits};
                    sp_next    = sp_reg - SP_ONE;
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Load the response slot; any non-ok status halts the machine.
        if (finish)
        begin
            rsp_valid_next = 1'b1;
            status_next    = finish_status;
            halted_next    = (finish_status != ST_OK);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            result_reg    <= '0;
            halted_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            result_reg    <= result_next;
            halted_reg    <= halted_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        op_reg     <= op_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= stack_mem[mem_raddr];
        end
    end

    // Result and depth registers hold still while a response waits, so drive them out.
    assign sp_ext             = EXT_W'(sp_reg);
    assign resp.valid         = rsp_valid_reg;
    assign resp.status        = status_reg;
    assign resp.result_value  = result_reg;
    assign resp.stack_depth   = sp_ext[DEPTH_W-1:0];

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_FULL)
        else $error("stack pointer beyond stack depth");

    a_busy_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !rsp_valid_reg)
        else $error("response pending while an instruction is in flight");

    a_halt_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(halted_reg) |-> (rsp_valid_reg && status_reg != ST_OK))
        else $error("halt without an error response");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIVIDE |-> right_reg != '0)
        else $error("divider running with zero divisor");

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import bsm_pkg::*;

    localparam int STACK_DEPTH    = 256;
    localparam int TOTAL_WORDS    = 1700;   // directed + fill + random words
    localparam int MAX_IDLE       = 18;
    localparam int LONG_HOLD      = 400;    // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES   = 40;     // covers the longest instruction, the divide, with margin
    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no word moving on either side

    // One response word: status, result register and stack depth.
    typedef struct packed {
        status_t              status;
        data_t                value;
        logic [DEPTH_W-1:0]   depth;
    } machine_rsp_t;

    // Directed row: opcode, immediate and, where obvious, a typed-in response.
    typedef struct {
        data_t         code;
        data_t         imm;
        bit            typed;
        machine_rsp_t  rsp;
    } stim_row_t;

    logic clk;
    logic rst_n;

    bsm_cmd_if instr_if ();
    bsm_rsp_if resp_if ();

    byte_stack_machine #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .instr (instr_if),
        .resp  (resp_if)
    );

    // Shadow copy of the machine state, advanced once per accepted command word.
    data_t        stack_mem [STACK_DEPTH];
    int unsigned  sp_model;
    data_t        result_model;
    bit           halted_model;

    machine_rsp_t expected_rsp [$];
    machine_rsp_t front_rsp;
    stim_row_t    directed_rows [0:22];

    int  errors;
    int  words_sent;
    int  rsps_taken;
    int  quiet_cycles;
    bit  sender_idles;
    bit  receiver_idles;
    bit  hold_off_req;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Execute one instruction on the shadow state and return the response word
    // the block must produce for it.
    function automatic machine_rsp_t exec_instruction(data_t code, data_t imm);
        machine_rsp_t r;
        data_t        lhs;
        data_t        rhs;
        data_t        res;
        status_t      st;
        // A halted machine restarts: empty stack, cleared result.
        if (halted_model)
        begin
            sp_model     = 0;
            result_model = '0;
            halted_model = 1'b0;
        end
        st = ST_OK;
        case (code)
            OP_PUSH:
                if (sp_model >= STACK_DEPTH)
                    st = ST_OVERFLOW;
                else
                begin
                    stack_mem[sp_model] = imm;
                    sp_model++;
                end
            OP_ADD, OP_SUB, OP_DIV, OP_MUL:
                if (sp_model < 2)
                    st = ST_UNDERFLOW;
                else
                begin
                    // Top of stack is the left operand, the one below it the right.
                    lhs = stack_mem[sp_model - 1];
                    rhs = stack_mem[sp_model - 2];
                    if (code == OP_DIV && rhs == '0)
                        st = ST_DIVZERO;
                    else
                    begin
                        case (code)
                            OP_ADD:  res = lhs + rhs;
                            OP_SUB:  res = lhs - rhs;
                            OP_DIV:  res = lhs / rhs;
                            default: res = lhs * rhs;
                        endcase
                        sp_model--;
                        stack_mem[sp_model - 1] = res;
                    end
                end
            OP_POP:
                if (sp_model < 1)
                    st = ST_UNDERFLOW;
                else
                begin
                    sp_model--;
                    result_model = stack_mem[sp_model];
                end
            OP_DONE:
                st = ST_DONE;
            default:
                st = ST_UNKNOWN;
        endcase
        if (st != ST_OK)
            halted_model = 1'b1;
        r.status = st;
        r.value  = result_model;
        r.depth  = sp_model[DEPTH_W-1:0];
        return r;
    endfunction

    // Offer one command word: idle first if the sender is in an idle phase, then
    // hold valid with the payload until ready. Valid stays high afterwards so a
    // back-to-back word does not see a low-then-high in the same step.
    task automatic send_word(input data_t code, input data_t imm, input bit typed,
                             input machine_rsp_t typed_rsp);
        int           gap;
        machine_rsp_t model_rsp;
        gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0)
        begin
            instr_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        instr_if.valid     <= 1'b1;
        instr_if.cmd       <= code;
        instr_if.immediate <= imm;
        do
            @(posedge clk);
        while (!instr_if.ready);
        // Word accepted at this edge: advance the shadow state.
        model_rsp = exec_instruction(code, imm);
        expected_rsp.push_back(typed ? typed_rsp : model_rsp);
        words_sent++;
        if (words_sent % 150 == 0)
            sender_idles = ~sender_idles;
    endtask

    // Drop valid and hold the sender until every response has come back.
    task automatic drain_responses();
        instr_if.valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    // A short program with random content: mostly pushes and arithmetic that
    // keep the stack legal, some pops, a little noise, usually closed by done.
    task automatic run_program();
        int    len;
        int    k;
        int    pick;
        int    depth;
        data_t code;
        data_t imm;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(3, 25);
        for (k = 0; k < len; k++)
        begin
            depth = halted_model ? 0 : sp_model;
            pick  = $urandom_range(0, 99);
            imm   = 8'($urandom_range(0, 255));
            // Bias toward zero so divide by zero shows up often enough.
            if ($urandom_range(0, 7) == 0)
                imm = '0;
            if (pick < 5)
                code = 8'($urandom_range(0, 255));
            else if (pick < 50 || (depth < 2 && pick < 88 && $urandom_range(0, 9) != 0))
                code = OP_PUSH;
            else if (pick < 88)
            begin
                case ($urandom_range(0, 3))
                    0:       code = OP_ADD;
                    1:       code = OP_SUB;
                    2:       code = OP_DIV;
                    default: code = OP_MUL;
                endcase
            end
            else
                code = OP_POP;
            send_word(code, imm, 1'b0, '0);
        end
        if ($urandom_range(0, 9) < 7)
            send_word(OP_DONE, 8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    // Stimulus
    initial
    begin
        int  i;
        bit  hold_done;
        bit  pause_done;

        rst_n              = 1'b0;
        instr_if.valid     <= 1'b0;
        instr_if.cmd       <= '0;
        instr_if.immediate <= '0;
        errors         = 0;
        words_sent     = 0;
        sender_idles   = 1'b1;
        hold_off_req   = 1'b0;
        hold_done      = 1'b0;
        pause_done     = 1'b0;
        sp_model       = 0;
        result_model   = '0;
        halted_model   = 1'b0;

        // Directed rows: typed-in responses where they are obvious, the
        // shadow model everywhere else.
        directed_rows = '{
            // empty stack after reset
            '{OP_ADD,  8'h00, 1'b1, '{ST_UNDERFLOW, 8'h00, 9'd0}},
            '{OP_POP,  8'h00, 1'b1, '{ST_UNDERFLOW, 8'h00, 9'd0}},
            '{8'hFF,   8'hFF, 1'b1, '{ST_UNKNOWN,   8'h00, 9'd0}},
            '{OP_DONE, 8'h3C, 1'b1, '{ST_DONE,      8'h00, 9'd0}},
            // zero divisor sits below the top
            '{OP_PUSH, 8'h00, 1'b1, '{ST_OK,        8'h00, 9'd1}},
            '{OP_PUSH, 8'h07, 1'b1, '{ST_OK,        8'h00, 9'd2}},
            '{OP_DIV,  8'hFF, 1'b1, '{ST_DIVZERO,   8'h00, 9'd2}},
            // restart after the error, then wrap-around arithmetic
            '{OP_PUSH, 8'hFF, 1'b1, '{ST_OK,        8'h00, 9'd1}},
            '{OP_PUSH, 8'hFF, 1'b1, '{ST_OK,        8'h00, 9'd2}},
            '{OP_MUL,  8'h81, 1'b0, '0},
            '{OP_PUSH, 8'h00, 1'b0, '0},
            '{OP_SUB,  8'h42, 1'b0, '0},
            '{OP_PUSH, 8'hC8, 1'b0, '0},
            '{OP_ADD,  8'h5A, 1'b0, '0},
            '{OP_PUSH, 8'hFA, 1'b0, '0},
            '{OP_DIV,  8'h00, 1'b0, '0},
            '{OP_POP,  8'hA5, 1'b0, '0},
            '{OP_POP,  8'h00, 1'b0, '0},
            // restart clears the result register
            '{OP_PUSH, 8'h09, 1'b1, '{ST_OK,        8'h00, 9'd1}},
            '{8'h07,   8'h00, 1'b1, '{ST_UNKNOWN,   8'h00, 9'd1}},
            '{8'h80,   8'h11, 1'b1, '{ST_UNKNOWN,   8'h00, 9'd0}},
            '{OP_PUSH, 8'h05, 1'b1, '{ST_OK,        8'h00, 9'd1}},
            '{OP_DONE, 8'h00, 1'b1, '{ST_DONE,      8'h00, 9'd1}}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < 23; i++)
            send_word(directed_rows[i].code, directed_rows[i].imm,
                      directed_rows[i].typed, directed_rows[i].rsp);

        // Fill the stack to the top, combine the two top entries at full depth,
        // refill, then push once more for the overflow.
        for (i = 0; i < STACK_DEPTH; i++)
            send_word(OP_PUSH, 8'($urandom_range(0, 255)), 1'b0, '0);
        send_word(OP_MUL, 8'h00, 1'b0, '0);
        send_word(OP_PUSH, 8'h01, 1'b0, '0);
        send_word(OP_PUSH, 8'hEE, 1'b0, '0);

        while (words_sent < TOTAL_WORDS)
        begin
            run_program();
            // Long receiver stall while the sender keeps offering words.
            if (!hold_done && words_sent > 700)
            begin
                hold_done    = 1'b1;
                hold_off_req = 1'b1;
            end
            // Sender pause until the pipeline is empty.
            if (!pause_done && words_sent > 1200)
            begin
                pause_done = 1'b1;
                drain_responses();
            end
        end

        drain_responses();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Response side: draw a stall per word, honor a long hold-off on request,
    // and run some stretches with ready held high.
    initial
    begin
        int stall;
        resp_if.ready  <= 1'b0;
        receiver_idles = 1'b1;
        rsps_taken     = 0;
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall        = LONG_HOLD;
            end
            else
                stall = receiver_idles ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall != 0)
            begin
                resp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            resp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rst_n && resp_if.valid));
            rsps_taken++;
            if (rsps_taken % 120 == 0)
                receiver_idles = ~receiver_idles;
        end
    end

    // Compare each accepted response word with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && resp_if.valid && resp_if.ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("response word with nothing expected: status %0d value %0d depth %0d",
                       resp_if.status, resp_if.result_value, resp_if.stack_depth);
                errors++;
            end
            else
            begin
                front_rsp = expected_rsp.pop_front();
                if (resp_if.status !== front_rsp.status)
                begin
                    $error("status: expected %0d, got %0d", front_rsp.status, resp_if.status);
                    errors++;
                end
                if (resp_if.result_value !== front_rsp.value)
                begin
                    $error("result_value: expected %0d, got %0d",
                           front_rsp.value, resp_if.result_value);
                    errors++;
                end
                if (resp_if.stack_depth !== front_rsp.depth)
                begin
                    $error("stack_depth: expected %0d, got %0d",
                           front_rsp.depth, resp_if.stack_depth);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    always @(posedge clk)
    begin
        if ((instr_if.valid && instr_if.ready) || (resp_if.valid && resp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
        quiet_cycles = 0;

endmodule

@@ sim.f @@
hw/rtl/bsm_pkg.sv
hw/rtl/bsm_cmd_if.sv
hw/rtl/bsm_rsp_if.sv
hw/rtl/byte_stack_machine.sv
dv/tb.sv
